[design/sell_pkg.sv]
// shared types, widths and saturation helpers for the two-lane sliced ellpack spmv
// used by sell_lane and sliced_ell_spmv_two_lane; depends on nothing else
package sell_pkg;

  localparam int SELL_VEC_DEPTH = 1024;
  localparam int SELL_LANES     = 2;
  localparam int IDX_W          = 10;
  localparam int DATA_W         = 32;
  localparam int PROD_W         = 2 * DATA_W;
  localparam int FRAC_W         = 16;
  localparam int ACC_W          = PROD_W - FRAC_W;
  localparam int CNT_W          = 16;
  localparam int IN_TDATA_W     = 192;
  localparam int OUT_TDATA_W    = 2 * DATA_W + CNT_W;
  localparam int OUT_QDEPTH     = 8;

  typedef enum logic {
    SELL_OP_VEC_WRITE = 1'b0,
    SELL_OP_SLICE     = 1'b1
  } sell_op_t;

  // pipeline control that travels alongside a slice request
  typedef struct packed {
    logic valid;
    logic slice;
    logic last;
  } sell_ctl_t;

  // input tdata, last declared field in the lowest bits
  typedef struct packed {
    logic                     pad;
    logic signed [DATA_W-1:0] prior1;
    logic signed [DATA_W-1:0] prior0;
    logic                     has_slice;
    logic [IDX_W-1:0]         lane1_column;
    logic signed [DATA_W-1:0] lane1_value;
    logic [IDX_W-1:0]         lane0_column;
    logic signed [DATA_W-1:0] lane0_value;
    logic signed [DATA_W-1:0] vec_value;
    logic [IDX_W-1:0]         vec_index;
  } sell_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]         chunk_number;
    logic signed [DATA_W-1:0] row_sum1;
    logic signed [DATA_W-1:0] row_sum0;
  } sell_out_t;

  // one extra bit of sum saturated back to the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
    logic signed [ACC_W-1:0] r;
    begin
      if (s[ACC_W] != s[ACC_W-1]) begin
        r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        r = s[ACC_W-1:0];
      end
      return r;
    end
  endfunction

  // accumulator plus prior clamped to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [ACC_W:0] s);
    logic signed [DATA_W-1:0] r;
    logic                     hi_same;
    begin
      hi_same = (s[ACC_W:DATA_W-1] == {(ACC_W-DATA_W+2){s[ACC_W]}});
      if (!hi_same) begin
        r = s[ACC_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        r = s[DATA_W-1:0];
      end
      return r;
    end
  endfunction

endpackage

[design/sell_lane.sv]
// one lane of the spmv datapath: registered q16.16 multiply, then saturating accumulate
// depends on sell_pkg
module sell_lane
  import sell_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  sell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] vec,
  output logic signed [ACC_W-1:0]  end_sum
);

  sell_ctl_t                ctl_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [ACC_W:0]    sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= value * vec;
  end

  // arithmetic shift rounds toward minus infinity
  assign prod_q = ACC_W'(prod >>> FRAC_W);
  assign sum    = {acc[ACC_W-1], acc} + {prod_q[ACC_W-1], prod_q};

  always_comb begin
    acc_next = acc;
    if (ctl_q.valid && ctl_q.slice) begin
      acc_next = sat_acc(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl_q.valid && ctl_q.last) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_q.valid && ctl_q.last) begin
      end_sum <= acc_next;
    end
  end

endmodule

[design/sliced_ell_spmv_two_lane.sv]
// top level of the two-lane sliced ellpack sparse matrix times vector block
// holds the vector store, pipeline control and output queue; depends on sell_pkg, sell_lane
//
// usage:
//   s_axis: one request per cycle while s_tready is high. tuser is op: vector write (store vec_value at
//   vec_index) or matrix slice. tlast is chunk_end; a slice with tlast high closes
//   the chunk and produces one result. has_slice low marks an empty close.
//   m_axis: one result per closed chunk: row_sum0, row_sum1, chunk_number.
//   cfg: one-bit accumulate_mode; user writes only while the block is idle (not enforced).
// timing:
//   a closing slice passes the s1 registers, lane product, lane end_sum and queue to m_axis.
//   one request per cycle sustained while s_tready is high: the vector store
//   reads both lane columns in the accepting cycle, each lane multiplier is
//   registered, and the accumulators update every cycle; a vector write is seen
//   by a slice accepted in the next cycle.
//   results wait in an 8-entry queue; s_tready drops while 8 results are
//   accepted but not taken, so a stalled receiver holds the input side once
//   the queue is spoken for, and nothing is lost.
// reset: accumulators, chunk counter, queue and accumulate_mode clear; the
//   vector store keeps whatever it held and must be written before use.
module sliced_ell_spmv_two_lane
  import sell_pkg::*;
#(
  parameter int VEC_DEPTH = SELL_VEC_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // vec_index, vec_value, lane0_value, lane0_column, lane1_value, lane1_column,
  // has_slice, prior0, prior1, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,   // chunk_end
  input  logic                   s_tuser,   // op
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // row_sum0, row_sum1, chunk_number
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_data   // accumulate_mode
);

  localparam int AW     = $clog2(VEC_DEPTH);
  localparam int EXT_W  = AW + IDX_W + 1;
  localparam int QAW    = $clog2(OUT_QDEPTH);
  localparam int QCNT_W = $clog2(OUT_QDEPTH + 1);

  sell_in_t                 req;
  logic                     accept;
  logic                     acc_mode;
  logic                     wr_en;
  logic [EXT_W-1:0]         wr_ext;
  logic [EXT_W-1:0]         rd_ext   [SELL_LANES];
  logic [AW-1:0]            rd_addr  [SELL_LANES];
  logic                     rd_ok    [SELL_LANES];
  logic signed [DATA_W-1:0] lane_val [SELL_LANES];
  logic signed [DATA_W-1:0] prior_in [SELL_LANES];

  logic [DATA_W-1:0]        vec_mem  [VEC_DEPTH];
  logic [DATA_W-1:0]        rd_data  [SELL_LANES];

  sell_ctl_t                s1_ctl;
  sell_ctl_t                s2_ctl;
  logic                     s3_valid;
  logic signed [DATA_W-1:0] s1_value [SELL_LANES];
  logic                     s1_ok    [SELL_LANES];
  logic signed [DATA_W-1:0] s1_prior [SELL_LANES];
  logic signed [DATA_W-1:0] s2_prior [SELL_LANES];
  logic signed [DATA_W-1:0] s3_prior [SELL_LANES];
  logic signed [DATA_W-1:0] vec_in   [SELL_LANES];
  logic signed [ACC_W-1:0]  end_sum  [SELL_LANES];
  logic signed [DATA_W-1:0] row_sum  [SELL_LANES];
  logic [CNT_W-1:0]         chunk_cnt;
  logic [CNT_W-1:0]         s3_chunk;

  sell_out_t                q_mem    [OUT_QDEPTH];
  sell_out_t                q_wdata;
  logic [QAW-1:0]           q_head;
  logic [QAW-1:0]           q_tail;
  logic [QCNT_W-1:0]        q_count;
  logic [QCNT_W-1:0]        pend;
  logic                     q_push;
  logic                     q_pop;
  logic                     res_req;

  assign req       = sell_in_t'(s_tdata);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      acc_mode <= cfg_data[0];
    end
  end

  // ---------------------------------------------------------------------------
  // vector store: one write port, two registered read ports
  // ---------------------------------------------------------------------------
  assign lane_val[0] = req.lane0_value;
  assign lane_val[1] = req.lane1_value;
  assign prior_in[0] = req.prior0;
  assign prior_in[1] = req.prior1;
  assign rd_ext[0]   = EXT_W'(req.lane0_column);
  assign rd_ext[1]   = EXT_W'(req.lane1_column);
  assign wr_ext      = EXT_W'(req.vec_index);
  // indexes past the store depth are dropped on write and read as zero
  assign wr_en       = accept && (sell_op_t'(s_tuser) == SELL_OP_VEC_WRITE) &&
                       (wr_ext < EXT_W'(VEC_DEPTH));

  for (genvar g = 0; g < SELL_LANES; g++) begin : g_addr
    assign rd_addr[g] = rd_ext[g][AW-1:0];
    assign rd_ok[g]   = rd_ext[g] < EXT_W'(VEC_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vec_mem[wr_ext[AW-1:0]] <= req.vec_value;
    end
    if (accept) begin
      for (int i = 0; i < SELL_LANES; i++) begin
        rd_data[i] <= vec_mem[rd_addr[i]];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control and side data
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl    <= '0;
      s2_ctl    <= '0;
      s3_valid  <= 1'b0;
      chunk_cnt <= '0;
    end else begin
      s1_ctl.valid <= accept && (sell_op_t'(s_tuser) == SELL_OP_SLICE);
      s1_ctl.slice <= req.has_slice;
      s1_ctl.last  <= s_tlast;
      s2_ctl       <= s1_ctl;
      s3_valid     <= s2_ctl.valid && s2_ctl.last;
      if (s2_ctl.valid && s2_ctl.last) begin
        chunk_cnt <= chunk_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SELL_LANES; i++) begin
      s1_value[i] <= lane_val[i];
      s1_ok[i]    <= rd_ok[i];
      s1_prior[i] <= prior_in[i];
      s2_prior[i] <= s1_prior[i];
      s3_prior[i] <= s2_prior[i];
    end
    s3_chunk <= chunk_cnt;
  end

  for (genvar g = 0; g < SELL_LANES; g++) begin : g_lane
    assign vec_in[g] = s1_ok[g] ? rd_data[g] : '0;

    sell_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (s1_ctl),
      .value   (s1_value[g]),
      .vec     (vec_in[g]),
      .end_sum (end_sum[g])
    );

    assign row_sum[g] = sat_out({end_sum[g][ACC_W-1], end_sum[g]} +
                                (acc_mode ? (ACC_W+1)'(s3_prior[g]) : '0));
  end

  // ---------------------------------------------------------------------------
  // output queue with reservation at acceptance
  // ---------------------------------------------------------------------------
  assign q_wdata.row_sum0     = row_sum[0];
  assign q_wdata.row_sum1     = row_sum[1];
  assign q_wdata.chunk_number = s3_chunk;

  assign q_push   = s3_valid;
  assign q_pop    = m_tvalid && m_tready;
  assign res_req  = accept && (sell_op_t'(s_tuser) == SELL_OP_SLICE) && s_tlast;
  assign s_tready = pend < QCNT_W'(OUT_QDEPTH);
  assign m_tvalid = q_count != '0;
  assign m_tdata  = q_mem[q_head];

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[q_tail] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_head  <= '0;
      q_tail  <= '0;
      q_count <= '0;
      pend    <= '0;
    end else begin
      if (q_push) begin
        q_tail <= q_tail + 1'b1;
      end
      if (q_pop) begin
        q_head <= q_head + 1'b1;
      end
      q_count <= q_count + QCNT_W'(q_push) - QCNT_W'(q_pop);
      pend    <= pend + QCNT_W'(res_req) - QCNT_W'(q_pop);
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= QCNT_W'(OUT_QDEPTH))
    else $error("result reservations exceed queue depth");

  a_queue_within_pend: assert property (@(posedge clk) disable iff (rst)
    q_count <= pend)
    else $error("queue holds more results than were reserved");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_count < QCNT_W'(OUT_QDEPTH)) || q_pop)
    else $error("push into a full output queue");

  a_chunk_step: assert property (@(posedge clk) disable iff (rst)
    (s2_ctl.valid && s2_ctl.last) |=> chunk_cnt == $past(chunk_cnt) + 1'b1)
    else $error("chunk counter did not advance on chunk close");

  a_close_reaches_queue: assert property (@(posedge clk) disable iff (rst)
    (s1_ctl.valid && s1_ctl.last) |=> ##1 q_push)
    else $error("chunk close did not reach the output queue");

endmodule
